// ===== src/eaba_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// eaba_pkg
// shared constants for the euler acceleration to body angular acceleration core
// ============================================================================
package eaba_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_FRAC    = 30;
    localparam int TRIG_W       = 34;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

// ===== src/euler_acc_to_body_angacc_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// euler_acc_to_body_angacc_core
// zyx euler angle accelerations to body-frame angular acceleration
// ============================================================================
// usage
//   s_axis carries one sample per transaction: roll and pitch binary angles
//   and the three euler rates and accelerations packed in s_axis_tdata.
//   m_axis returns body x, y, z angular acceleration in m_axis_tdata and the
//   saturation flag in m_axis_tuser, one transaction per input transaction.
//   the pipeline from input transaction to output valid has a register
//   stage for the angle fold, 30 cordic iteration stages, one stage for the
//   quadrant fix, then multiply, round, multiply, round and sum stages.
//   throughput is one sample per cycle while m_axis is not stalled; every
//   stage holds one sample. the whole pipeline advances together; when
//   m_axis is stalled with a result waiting, all stages hold and s_axis_tready
//   drops, so nothing is lost or repeated.
//   reset clears all valid bits; data registers are not reset.
// ============================================================================
module euler_acc_to_body_angacc_core #(
    parameter int ANGLE_BITS = 16,
    parameter int RATE_BITS  = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
    // roll_accel, pitch_accel, yaw_accel, zero pad
    input  logic [((2*ANGLE_BITS+6*RATE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // body_acc_x, body_acc_y, body_acc_z, zero pad
    output logic [((3*RATE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic m_axis_tuser
);
    import eaba_pkg::*;

    localparam int NS    = CORDIC_STEPS;
    localparam int TW    = TRIG_W;
    localparam int RB    = RATE_BITS;
    localparam int VW    = (RB > 32) ? RB : 32;
    localparam int PW    = 2 * ((RB > TW) ? RB : TW);
    localparam int SW    = RB + 3;
    localparam int RO    = 2 * ANGLE_BITS;
    localparam int OUT_W = ((3*RATE_BITS+7)/8)*8;

    function automatic logic [VW:0] rnd_sat(input logic signed [PW-1:0] p,
                                            input int s, input int bits);
        logic          neg;
        logic [PW:0]   mag;
        logic [PW:0]   q;
        logic [PW:0]   lim;
        logic          sat;
        neg = p[PW-1];
        mag = neg ? ({1'b0, ~p} + 1'b1) : {1'b0, p};
        q   = (mag + ({{PW{1'b0}}, 1'b1} << (s-1))) >> s;
        lim = ({{PW{1'b0}}, 1'b1} << (bits-1)) - {{PW{1'b0}}, ~neg};
        sat = (q > lim);
        if (sat)
        begin
            q = lim;
        end
        if (neg)
        begin
            q = ~q + 1'b1;
        end
        return {sat, q[VW-1:0]};
    endfunction

    function automatic logic [RB:0] clip(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'((65'sd1 <<< (RB-1)) - 65'sd1);
        lo = -hi - SW'(1);
        if (v > hi)
        begin
            return {1'b1, hi[RB-1:0]};
        end
        if (v < lo)
        begin
            return {1'b1, lo[RB-1:0]};
        end
        return {1'b0, v[RB-1:0]};
    endfunction

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- angle fold into cordic start ----------------
    logic [31:0] ra_a, pa_a, ra_f, pa_f;
    logic        ra_flip, pa_flip;
    always_comb
    begin
        ra_a    = {s_axis_tdata[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        pa_a    = {s_axis_tdata[RO-1:ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
        ra_f    = ra_a + 32'h40000000;
        pa_f    = pa_a + 32'h40000000;
        ra_flip = ra_f[31];
        pa_flip = pa_f[31];
    end

    logic signed [TW-1:0] rcx_reg [0:NS];
    logic signed [TW-1:0] rcy_reg [0:NS];
    logic signed [TW-1:0] rcz_reg [0:NS];
    logic signed [TW-1:0] pcx_reg [0:NS];
    logic signed [TW-1:0] pcy_reg [0:NS];
    logic signed [TW-1:0] pcz_reg [0:NS];
    logic                 rfl_reg [0:NS];
    logic                 pfl_reg [0:NS];
    logic [6*RB-1:0]      rates_reg [0:NS];
    logic                 cv_reg [0:NS];

    logic signed [TW-1:0] rcx_next [0:NS-1];
    logic signed [TW-1:0] rcy_next [0:NS-1];
    logic signed [TW-1:0] rcz_next [0:NS-1];
    logic signed [TW-1:0] pcx_next [0:NS-1];
    logic signed [TW-1:0] pcy_next [0:NS-1];
    logic signed [TW-1:0] pcz_next [0:NS-1];

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (!rcz_reg[i][TW-1])
            begin
                rcx_next[i] = rcx_reg[i] - (rcy_reg[i] >>> i);
                rcy_next[i] = rcy_reg[i] + (rcx_reg[i] >>> i);
                rcz_next[i] = rcz_reg[i] - TW'(ATAN_TURNS[i]);
            end
            else
            begin
                rcx_next[i] = rcx_reg[i] + (rcy_reg[i] >>> i);
                rcy_next[i] = rcy_reg[i] - (rcx_reg[i] >>> i);
                rcz_next[i] = rcz_reg[i] + TW'(ATAN_TURNS[i]);
            end
            if (!pcz_reg[i][TW-1])
            begin
                pcx_next[i] = pcx_reg[i] - (pcy_reg[i] >>> i);
                pcy_next[i] = pcy_reg[i] + (pcx_reg[i] >>> i);
                pcz_next[i] = pcz_reg[i] - TW'(ATAN_TURNS[i]);
            end
            else
            begin
                pcx_next[i] = pcx_reg[i] + (pcy_reg[i] >>> i);
                pcy_next[i] = pcy_reg[i] - (pcx_reg[i] >>> i);
                pcz_next[i] = pcz_reg[i] + TW'(ATAN_TURNS[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            cv_reg[0] <= s_axis_tvalid;
            for (int i = 0; i < NS; i++)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rcx_reg[0]   <= CORDIC_GAIN;
            rcy_reg[0]   <= '0;
            rcz_reg[0]   <= TW'($signed({ra_a[31] ^ ra_flip, ra_a[30:0]}));
            pcx_reg[0]   <= CORDIC_GAIN;
            pcy_reg[0]   <= '0;
            pcz_reg[0]   <= TW'($signed({pa_a[31] ^ pa_flip, pa_a[30:0]}));
            rfl_reg[0]   <= ra_flip;
            pfl_reg[0]   <= pa_flip;
            rates_reg[0] <= s_axis_tdata[RO+6*RB-1:RO];
            for (int i = 0; i < NS; i++)
            begin
                rcx_reg[i+1]   <= rcx_next[i];
                rcy_reg[i+1]   <= rcy_next[i];
                rcz_reg[i+1]   <= rcz_next[i];
                pcx_reg[i+1]   <= pcx_next[i];
                pcy_reg[i+1]   <= pcy_next[i];
                pcz_reg[i+1]   <= pcz_next[i];
                rfl_reg[i+1]   <= rfl_reg[i];
                pfl_reg[i+1]   <= pfl_reg[i];
                rates_reg[i+1] <= rates_reg[i];
            end
        end
    end

    // ---------------- quadrant fix ----------------
    logic signed [TW-1:0] sr_reg, cr_reg, sp_reg, cp_reg;
    logic [6*RB-1:0]      trates_reg;
    logic                 tv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg     <= rfl_reg[NS] ? -rcy_reg[NS] : rcy_reg[NS];
            cr_reg     <= rfl_reg[NS] ? -rcx_reg[NS] : rcx_reg[NS];
            sp_reg     <= pfl_reg[NS] ? -pcy_reg[NS] : pcy_reg[NS];
            cp_reg     <= pfl_reg[NS] ? -pcx_reg[NS] : pcx_reg[NS];
            trates_reg <= rates_reg[NS];
        end
    end

    logic signed [RB-1:0] dr, dp, dy;
    assign dr = trates_reg[RB-1:0];
    assign dp = trates_reg[2*RB-1:RB];
    assign dy = trates_reg[3*RB-1:2*RB];

    // ---------------- first products ----------------
    logic signed [2*TW-1:0] srsp_p_reg, srcp_p_reg, crsp_p_reg, crcp_p_reg;
    logic signed [2*RB-1:0] pd_p_reg, py_p_reg, yr_p_reg;
    logic signed [TW-1:0]   sr1_reg, cr1_reg, sp1_reg, cp1_reg;
    logic [3*RB-1:0]        acc1_reg;
    logic                   m1v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_p_reg <= sr_reg * sp_reg;
            srcp_p_reg <= sr_reg * cp_reg;
            crsp_p_reg <= cr_reg * sp_reg;
            crcp_p_reg <= cr_reg * cp_reg;
            pd_p_reg   <= dr * dp;
            py_p_reg   <= dp * dy;
            yr_p_reg   <= dy * dr;
            sr1_reg    <= sr_reg;
            cr1_reg    <= cr_reg;
            sp1_reg    <= sp_reg;
            cp1_reg    <= cp_reg;
            acc1_reg   <= trates_reg[6*RB-1:3*RB];
        end
    end

    // ---------------- first rounding ----------------
    logic [VW:0] srsp_next, srcp_next, crsp_next, crcp_next, pd_next, py_next, yr_next;
    always_comb
    begin
        srsp_next = rnd_sat(PW'(srsp_p_reg), TRIG_FRAC, 32);
        srcp_next = rnd_sat(PW'(srcp_p_reg), TRIG_FRAC, 32);
        crsp_next = rnd_sat(PW'(crsp_p_reg), TRIG_FRAC, 32);
        crcp_next = rnd_sat(PW'(crcp_p_reg), TRIG_FRAC, 32);
        pd_next   = rnd_sat(PW'(pd_p_reg), FRAC_BITS, RB);
        py_next   = rnd_sat(PW'(py_p_reg), FRAC_BITS, RB);
        yr_next   = rnd_sat(PW'(yr_p_reg), FRAC_BITS, RB);
    end

    logic signed [TW-1:0] srsp_reg, srcp_reg, crsp_reg, crcp_reg;
    logic signed [TW-1:0] sr2_reg, cr2_reg, sp2_reg, cp2_reg;
    logic signed [RB-1:0] pd_reg, py_reg, yr_reg;
    logic [3*RB-1:0]      acc2_reg;
    logic                 sat1_reg;
    logic                 r1v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_reg <= TW'($signed(srsp_next[31:0]));
            srcp_reg <= TW'($signed(srcp_next[31:0]));
            crsp_reg <= TW'($signed(crsp_next[31:0]));
            crcp_reg <= TW'($signed(crcp_next[31:0]));
            pd_reg   <= pd_next[RB-1:0];
            py_reg   <= py_next[RB-1:0];
            yr_reg   <= yr_next[RB-1:0];
            sat1_reg <= srsp_next[VW] | srcp_next[VW] | crsp_next[VW] | crcp_next[VW]
                      | pd_next[VW] | py_next[VW] | yr_next[VW];
            sr2_reg  <= sr1_reg;
            cr2_reg  <= cr1_reg;
            sp2_reg  <= sp1_reg;
            cp2_reg  <= cp1_reg;
            acc2_reg <= acc1_reg;
        end
    end

    logic signed [RB-1:0] ddr, ddp, ddy;
    assign ddr = acc2_reg[RB-1:0];
    assign ddp = acc2_reg[2*RB-1:RB];
    assign ddy = acc2_reg[3*RB-1:2*RB];

    // ---------------- second products ----------------
    logic signed [RB+TW-1:0] q_p_reg [0:11];
    logic signed [RB-1:0]    ddr3_reg;
    logic                    sat2_reg;
    logic                    m2v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_p_reg[0]  <= ddy * sp2_reg;
            q_p_reg[1]  <= py_reg * cp2_reg;
            q_p_reg[2]  <= ddp * cr2_reg;
            q_p_reg[3]  <= pd_reg * sr2_reg;
            q_p_reg[4]  <= ddy * srcp_reg;
            q_p_reg[5]  <= yr_reg * crcp_reg;
            q_p_reg[6]  <= py_reg * srsp_reg;
            q_p_reg[7]  <= ddp * sr2_reg;
            q_p_reg[8]  <= pd_reg * cr2_reg;
            q_p_reg[9]  <= ddy * crcp_reg;
            q_p_reg[10] <= yr_reg * srcp_reg;
            q_p_reg[11] <= py_reg * crsp_reg;
            ddr3_reg    <= ddr;
            sat2_reg    <= sat1_reg;
        end
    end

    // ---------------- second rounding ----------------
    logic [VW:0] q_next [0:11];
    logic        qsat_next;
    always_comb
    begin
        qsat_next = sat2_reg;
        for (int i = 0; i < 12; i++)
        begin
            q_next[i] = rnd_sat(PW'(q_p_reg[i]), TRIG_FRAC, RB);
            qsat_next = qsat_next | q_next[i][VW];
        end
    end

    logic signed [RB-1:0] q_reg [0:11];
    logic signed [RB-1:0] ddr4_reg;
    logic                 sat3_reg;
    logic                 r2v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 12; i++)
            begin
                q_reg[i] <= q_next[i][RB-1:0];
            end
            ddr4_reg <= ddr3_reg;
            sat3_reg <= qsat_next;
        end
    end

    // ---------------- sums and clip ----------------
    logic signed [SW-1:0] x_sum, y_sum, z_sum;
    logic [RB:0]          x_clip, y_clip, z_clip;
    always_comb
    begin
        x_sum  = SW'(ddr4_reg) - SW'(q_reg[0]) - SW'(q_reg[1]);
        y_sum  = SW'(q_reg[2]) - SW'(q_reg[3]) + SW'(q_reg[4]) + SW'(q_reg[5])
               - SW'(q_reg[6]);
        z_sum  = -SW'(q_reg[7]) - SW'(q_reg[8]) + SW'(q_reg[9]) - SW'(q_reg[10])
               - SW'(q_reg[11]);
        x_clip = clip(x_sum);
        y_clip = clip(y_sum);
        z_clip = clip(z_sum);
    end

    logic [OUT_W-1:0] tdata_reg;
    logic             tuser_reg;
    logic             ov_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= OUT_W'({z_clip[RB-1:0], y_clip[RB-1:0], x_clip[RB-1:0]});
            tuser_reg <= sat3_reg | x_clip[RB] | y_clip[RB] | z_clip[RB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg  <= 1'b0;
            m1v_reg <= 1'b0;
            r1v_reg <= 1'b0;
            m2v_reg <= 1'b0;
            r2v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            tv_reg  <= cv_reg[NS];
            m1v_reg <= tv_reg;
            r1v_reg <= m1v_reg;
            m2v_reg <= r1v_reg;
            r2v_reg <= m2v_reg;
            ov_reg  <= r2v_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output stage empty");

    a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg |-> (cr_reg <= 34'sd1073745920 && cr_reg >= -34'sd1073745920))
        else $error("cordic cosine out of range");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(r2v_reg) && $stable(tv_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

// ===== tb/sv/body_angacc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// body_angacc_checker
// watches both stream channels of the body angular acceleration core,
// predicts each result from the accepted sample and compares it in order
// ============================================================================
module body_angacc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
    // roll_accel, pitch_accel, yaw_accel
    input  logic [223:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // body_acc_x, body_acc_y, body_acc_z
    input  logic [95:0] m_axis_tdata,
    // saturated
    input  logic        m_axis_tuser,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [31:0] acc_x;
        logic [31:0] acc_y;
        logic [31:0] acc_z;
        logic        sat;
    } body_acc_t;

    body_acc_t body_acc_q[$];

    function automatic longint round_mul(longint a, longint b, int s, int bits,
                                         inout bit sat);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] mag;
        logic [127:0] lim;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 128'(-a) : 128'(a);
        ub  = (b < 0) ? 128'(-b) : 128'(b);
        mag = (ua * ub + (128'd1 << (s - 1))) >> s;
        lim = (128'd1 << (bits - 1)) - (neg ? 128'd0 : 128'd1);
        if (mag > lim)
        begin
            sat = 1'b1;
            mag = lim;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void angle_sincos(logic [15:0] ang, output longint sn,
                                         output longint cs);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a    = {ang, 16'h0000};
        flip = a[31] ^ a[30];
        if (flip)
            a = a + 32'h80000000;
        z = longint'($signed(a));
        x = longint'(eaba_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(eaba_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(eaba_pkg::ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic body_acc_t predict_body_acc(logic [223:0] d);
        body_acc_t r;
        bit        sat;
        longint    sr, cr, sp, cp, srsp, srcp, crsp, crcp, pd, py, yr;
        longint    dr, dp, dyw, ddr, ddp, ddy, x, y, z;
        sat = 1'b0;
        dr  = longint'($signed(d[63:32]));
        dp  = longint'($signed(d[95:64]));
        dyw = longint'($signed(d[127:96]));
        ddr = longint'($signed(d[159:128]));
        ddp = longint'($signed(d[191:160]));
        ddy = longint'($signed(d[223:192]));
        angle_sincos(d[15:0], sr, cr);
        angle_sincos(d[31:16], sp, cp);
        srsp = round_mul(sr, sp, 30, 32, sat);
        srcp = round_mul(sr, cp, 30, 32, sat);
        crsp = round_mul(cr, sp, 30, 32, sat);
        crcp = round_mul(cr, cp, 30, 32, sat);
        pd   = round_mul(dr, dp, 16, 32, sat);
        py   = round_mul(dp, dyw, 16, 32, sat);
        yr   = round_mul(dyw, dr, 16, 32, sat);
        x = ddr - round_mul(ddy, sp, 30, 32, sat) - round_mul(py, cp, 30, 32, sat);
        y = round_mul(ddp, cr, 30, 32, sat) - round_mul(pd, sr, 30, 32, sat)
          + round_mul(ddy, srcp, 30, 32, sat) + round_mul(yr, crcp, 30, 32, sat)
          - round_mul(py, srsp, 30, 32, sat);
        z = -round_mul(ddp, sr, 30, 32, sat) - round_mul(pd, cr, 30, 32, sat)
          + round_mul(ddy, crcp, 30, 32, sat) - round_mul(yr, srcp, 30, 32, sat)
          - round_mul(py, crsp, 30, 32, sat);
        x = clip32(x, sat);
        y = clip32(y, sat);
        z = clip32(z, sat);
        r.acc_x = x[31:0];
        r.acc_y = y[31:0];
        r.acc_z = z[31:0];
        r.sat   = sat;
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        body_acc_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            body_acc_q.push_back(predict_body_acc(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (body_acc_q.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t unexpected transaction: %h %b", $time, m_axis_tdata,
                         m_axis_tuser);
            end
            else
            begin
                want = body_acc_q.pop_front();
                if (m_axis_tdata[31:0] !== want.acc_x)
                begin
                    errors = errors + 1;
                    $display("%0t body_acc_x expected %h actual %h", $time,
                             want.acc_x, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[63:32] !== want.acc_y)
                begin
                    errors = errors + 1;
                    $display("%0t body_acc_y expected %h actual %h", $time,
                             want.acc_y, m_axis_tdata[63:32]);
                end
                if (m_axis_tdata[95:64] !== want.acc_z)
                begin
                    errors = errors + 1;
                    $display("%0t body_acc_z expected %h actual %h", $time,
                             want.acc_z, m_axis_tdata[95:64]);
                end
                if (m_axis_tuser !== want.sat)
                begin
                    errors = errors + 1;
                    $display("%0t saturated expected %b actual %b", $time,
                             want.sat, m_axis_tuser);
                end
            end
        end
        pending = body_acc_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// drives samples into the body angular acceleration core with directed
// corner cases and random samples under several idle and stall mixes
// ============================================================================
module testbench;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;

    euler_acc_to_body_angacc_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    body_angacc_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] ra, logic [15:0] pa, logic [31:0] dr,
                               logic [31:0] dp, logic [31:0] dy, logic [31:0] ar,
                               logic [31:0] ap, logic [31:0] ay);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ay, ap, ar, dy, dp, dr, pa, ra};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] rand_rate(int mode);
        case (mode)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(2097151)) - 1048576);
            default: return 32'($signed($urandom_range(33554431)) - 16777216);
        endcase
    endfunction

    task automatic send_random;
        int          mode;
        logic [15:0] ra;
        logic [15:0] pa;
        mode = $urandom_range(9);
        ra   = $urandom;
        pa   = $urandom;
        if (mode == 9)
            pa = (pa[0] ? 16'h4000 : 16'hC000) + 16'($signed($urandom_range(8)) - 4);
        send_sample(ra, pa, rand_rate(mode % 3), rand_rate(mode % 3),
                    rand_rate(mode % 3), rand_rate(mode % 3), rand_rate(mode % 3),
                    rand_rate(mode % 3));
    endtask

    initial
    begin
        logic [15:0] angles [0:7];
        angles = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h3FFF,
                   16'h0001, 16'hFFFF};
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner angles with unit rates and accelerations
        for (int i = 0; i < 8; i++)
            send_sample(angles[i], angles[7 - i], 32'h00010000, 32'h00010000,
                        32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
        // field extremes, product and sum overflow
        send_sample(16'h0000, 16'h0000, '0, '0, '0, '0, '0, '0);
        send_sample(16'h8000, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000);
        send_sample(16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sample(16'h2000, 16'hE000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_sample(16'h0000, 16'h4000, 32'h00000000, 32'h00000000, 32'h00000000,
                    32'h7FFFFFFF, 32'h00000000, 32'h80000000);
        send_sample(16'h0000, 16'hC000, 32'h00000000, 32'h00000000, 32'h00000000,
                    32'h80000000, 32'h00000000, 32'h7FFFFFFF);
        send_sample(16'h1234, 16'h4001, 32'h01000000, 32'h01000000, 32'h01000000,
                    32'h00000001, 32'hFFFFFFFF, 32'h00008000);
        send_sample(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 15 : 0;
            recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 15 : 0;
            for (int n = 0; n < 256; n++)
                send_random();
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/eaba_pkg.sv
src/euler_acc_to_body_angacc_core.sv
tb/sv/body_angacc_checker.sv
tb/sv/testbench.sv
